// ===== sv/bdq_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package bdq_pkg;

    localparam int DEPTH  = 16;
    localparam int DATA_W = 32;
    localparam int CNT_W  = $clog2(DEPTH + 1);

    typedef enum logic [2:0] {
        OP_ADD_BACK     = 3'd0,
        OP_ADD_FRONT    = 3'd1,
        OP_REMOVE_BACK  = 3'd2,
        OP_REMOVE_FRONT = 3'd3,
        OP_SEARCH       = 3'd4
    } bdq_op_t;

    typedef struct packed {
        logic add_front;
        logic add_back;
        logic rem_front;
        logic rem_back;
    } bdq_ctrl_t;

endpackage

`default_nettype wire

// ===== sv/bdq_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none

module bdq_cell
    import bdq_pkg::*;
(
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire bdq_ctrl_t                ctrl,
    input  wire logic signed [DATA_W-1:0] key,
    input  wire logic signed [DATA_W-1:0] left_data,
    input  wire logic                     left_valid,
    input  wire logic signed [DATA_W-1:0] right_data,
    input  wire logic                     right_valid,
    output logic signed [DATA_W-1:0]      data,
    output logic                          valid,
    output logic                          match
);

    logic signed [DATA_W-1:0] data_reg, data_next;
    logic                     valid_reg, valid_next;

    always_comb begin
        data_next  = data_reg;
        valid_next = valid_reg;
        if (ctrl.add_front) begin
            data_next  = left_data;
            valid_next = left_valid;
        end else if (ctrl.add_back) begin
            if (!valid_reg && left_valid) begin
                data_next  = key;
                valid_next = 1'b1;
            end
        end else if (ctrl.rem_front) begin
            data_next  = right_data;
            valid_next = right_valid;
        end else if (ctrl.rem_back) begin
            if (valid_reg && !right_valid) begin
                valid_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        data_reg <= data_next;
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    assign data  = data_reg;
    assign valid = valid_reg;
    assign match = valid_reg && (data_reg == key);

endmodule

`default_nettype wire

// ===== sv/bounded_deque_with_search.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Double-ended store of up to DEPTH signed 32-bit values with search by value.
// Entries sit in a row of cells, front at cell 0; adds and removes at the front
// shift the whole row by one, adds and removes at the back touch only the cell at
// the boundary of the filled part, and a search compares the key in every cell at
// once. One operation is taken every clock while m_valid is low or m_ready high;
// its result appears in the output register on the next cycle, and a new operation
// is taken while the result is taken. Row update and compare are combinational.
// An add to a full store or a remove from an empty store returns ok low and leaves
// the store unchanged; unused opcodes do the same.
module bounded_deque_with_search
    import bdq_pkg::*;
(
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire logic                     s_valid,
    output logic                          s_ready,
    input  wire logic [2:0]               s_opcode,
    input  wire logic signed [DATA_W-1:0] s_value,
    output logic                          m_valid,
    input  wire logic                     m_ready,
    output logic                          m_ok,
    output logic                          m_found,
    output logic [CNT_W-1:0]              m_count,
    output logic                          m_empty_res
);

    logic signed [DATA_W-1:0] cell_data [DEPTH];
    logic [DEPTH-1:0]         cell_valid;
    logic [DEPTH-1:0]         cell_match;

    bdq_ctrl_t        ctrl;
    logic             accept;
    logic             full;
    logic             empty;
    logic             ok_c;
    logic             found_c;

    logic [CNT_W-1:0] count_reg, count_next;
    logic             m_valid_reg, m_valid_next;
    logic             m_ok_reg, m_found_reg, m_empty_reg;
    logic [CNT_W-1:0] m_count_reg;

    assign s_ready = !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;
    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);

    always_comb begin
        ctrl       = '0;
        ok_c       = 1'b0;
        found_c    = 1'b0;
        count_next = count_reg;
        case (bdq_op_t'(s_opcode))
            OP_ADD_BACK: begin
                ok_c          = !full;
                ctrl.add_back = accept && !full;
            end
            OP_ADD_FRONT: begin
                ok_c           = !full;
                ctrl.add_front = accept && !full;
            end
            OP_REMOVE_BACK: begin
                ok_c          = !empty;
                ctrl.rem_back = accept && !empty;
            end
            OP_REMOVE_FRONT: begin
                ok_c           = !empty;
                ctrl.rem_front = accept && !empty;
            end
            OP_SEARCH: begin
                ok_c    = 1'b1;
                found_c = |cell_match;
            end
            default: begin
                ok_c = 1'b0;
            end
        endcase
        if (ctrl.add_back || ctrl.add_front) begin
            count_next = count_reg + CNT_W'(1);
        end else if (ctrl.rem_back || ctrl.rem_front) begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        logic signed [DATA_W-1:0] l_data, r_data;
        logic                     l_valid, r_valid;
        if (i == 0) begin : g_first
            assign l_data  = s_value;
            assign l_valid = 1'b1;
        end else begin : g_mid_l
            assign l_data  = cell_data[i-1];
            assign l_valid = cell_valid[i-1];
        end
        if (i == DEPTH - 1) begin : g_last
            assign r_data  = cell_data[i];
            assign r_valid = 1'b0;
        end else begin : g_mid_r
            assign r_data  = cell_data[i+1];
            assign r_valid = cell_valid[i+1];
        end
        bdq_cell u_cell (
            .aclk        (aclk),
            .aresetn     (aresetn),
            .ctrl        (ctrl),
            .key         (s_value),
            .left_data   (l_data),
            .left_valid  (l_valid),
            .right_data  (r_data),
            .right_valid (r_valid),
            .data        (cell_data[i]),
            .valid       (cell_valid[i]),
            .match       (cell_match[i])
        );
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (accept) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
        if (accept) begin
            m_ok_reg    <= ok_c;
            m_found_reg <= found_c;
            m_count_reg <= count_next;
            m_empty_reg <= (count_next == '0);
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_ok        = m_ok_reg;
    assign m_found     = m_found_reg;
    assign m_count     = m_count_reg;
    assign m_empty_res = m_empty_reg;

`ifndef SYNTHESIS
    a_count_matches_cells: assert property (@(posedge aclk) disable iff (!aresetn)
        $countones(cell_valid) == int'(count_reg))
        else $error("entry count differs from filled cells");

    a_cells_contiguous: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot({1'b0, cell_valid} + {{DEPTH{1'b0}}, 1'b1}))
        else $error("filled cells not packed at the front");

    a_add_grows: assert property (@(posedge aclk) disable iff (!aresetn)
        (ctrl.add_back || ctrl.add_front) |=> count_reg == $past(count_reg) + CNT_W'(1))
        else $error("add transfer did not grow the count");

    a_result_tracks_count: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> (m_count == count_reg) && (m_empty_res == (count_reg == '0)))
        else $error("result count differs from store");
`endif

endmodule

`default_nettype wire
